FILE: sv/tpgt_pkg.sv
package tpgt_pkg;

   localparam int COORD_W = 12;
   localparam int RAW_W = 16;
   localparam int TOTAL_W = 32;
   localparam int KIND_W = 3;
   localparam int CALC_W = 18;

   localparam logic [COORD_W-1:0] DEF_WIDTH = 12'd800;
   localparam logic [COORD_W-1:0] DEF_HEIGHT = 12'd480;
   localparam logic [COORD_W-1:0] DEF_SWIPE = 12'd50;

   localparam logic [KIND_W-1:0] EV_MOVE = 3'd0;
   localparam logic [KIND_W-1:0] EV_DOWN = 3'd1;
   localparam logic [KIND_W-1:0] EV_UP = 3'd2;
   localparam logic [KIND_W-1:0] EV_CLICK = 3'd3;
   localparam logic [KIND_W-1:0] EV_SWIPE = 3'd4;

   localparam logic [1:0] ROT_NONE = 2'd0;
   localparam logic [1:0] ROT_90 = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_WIDTH = 3'd1;
   localparam logic [2:0] REG_HEIGHT = 3'd2;
   localparam logic [2:0] REG_ROTATION = 3'd3;
   localparam logic [2:0] REG_FLIP_H = 3'd4;
   localparam logic [2:0] REG_FLIP_V = 3'd5;
   localparam logic [2:0] REG_SWIPE = 3'd6;

   typedef struct packed {
      logic               enable;
      logic [COORD_W-1:0] screen_width;
      logic [COORD_W-1:0] screen_height;
      logic [1:0]         rotation;
      logic               flip_horizontal;
      logic               flip_vertical;
      logic [COORD_W-1:0] swipe_distance;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]  event_kind;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               is_pressed;
      logic [TOTAL_W-1:0] event_total;
      logic               last_of_run;
   } evt_type;

endpackage

FILE: sv/tpgt_xform.sv
module tpgt_xform (
   input  tpgt_pkg::cfg_type                 cfg,
   input  logic [tpgt_pkg::RAW_W-1:0]        raw_x,
   input  logic [tpgt_pkg::RAW_W-1:0]        raw_y,
   output logic [tpgt_pkg::COORD_W-1:0]      point_x,
   output logic [tpgt_pkg::COORD_W-1:0]      point_y
);

   localparam int CW = tpgt_pkg::CALC_W;
   localparam int PW = tpgt_pkg::CALC_W - tpgt_pkg::COORD_W;
   localparam int RPW = tpgt_pkg::CALC_W - tpgt_pkg::RAW_W;

   logic [tpgt_pkg::COORD_W-1:0] w;
   logic [tpgt_pkg::COORD_W-1:0] h;
   logic signed [CW-1:0] ws;
   logic signed [CW-1:0] hs;
   logic signed [CW-1:0] wm;
   logic signed [CW-1:0] hm;
   logic signed [CW-1:0] rx;
   logic signed [CW-1:0] ry;
   logic signed [CW-1:0] rot_x;
   logic signed [CW-1:0] rot_y;
   logic signed [CW-1:0] nx;
   logic signed [CW-1:0] ny;

   always_comb begin
      w = (cfg.screen_width != '0) ? cfg.screen_width : tpgt_pkg::DEF_WIDTH;
      h = (cfg.screen_height != '0) ? cfg.screen_height : tpgt_pkg::DEF_HEIGHT;
      ws = $signed({{PW{1'b0}}, w});
      hs = $signed({{PW{1'b0}}, h});
      wm = ws - CW'(1);
      hm = hs - CW'(1);
      rx = $signed({{RPW{1'b0}}, raw_x});
      ry = $signed({{RPW{1'b0}}, raw_y});
      case (cfg.rotation)
         tpgt_pkg::ROT_90: begin
            rot_x = hm - ry;
            rot_y = rx;
         end
         tpgt_pkg::ROT_180: begin
            rot_x = wm - rx;
            rot_y = hm - ry;
         end
         tpgt_pkg::ROT_270: begin
            rot_x = ry;
            rot_y = wm - rx;
         end
         default: begin
            rot_x = rx;
            rot_y = ry;
         end
      endcase
      nx = cfg.flip_horizontal ? (wm - rot_x) : rot_x;
      ny = cfg.flip_vertical ? (hm - rot_y) : rot_y;
      if (nx < 0) begin
         point_x = '0;
      end else if (nx >= ws) begin
         point_x = wm[tpgt_pkg::COORD_W-1:0];
      end else begin
         point_x = nx[tpgt_pkg::COORD_W-1:0];
      end
      if (ny < 0) begin
         point_y = '0;
      end else if (ny >= hs) begin
         point_y = hm[tpgt_pkg::COORD_W-1:0];
      end else begin
         point_y = ny[tpgt_pkg::COORD_W-1:0];
      end
   end

endmodule

FILE: sv/tpgt_tracker.sv
module tpgt_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  tpgt_pkg::cfg_type             cfg,
   input  logic                          clear_press,
   input  logic                          in_valid,
   input  logic                          touched,
   input  logic [tpgt_pkg::RAW_W-1:0]    raw_x,
   input  logic [tpgt_pkg::RAW_W-1:0]    raw_y,
   input  logic                          read_failed,
   input  logic [1:0]                    free,
   output logic                          take,
   output logic [1:0]                    push_cnt,
   output tpgt_pkg::evt_type             ev0,
   output tpgt_pkg::evt_type             ev1
);

   localparam int XW = tpgt_pkg::COORD_W;

   logic          pressed_ff, pressed_in;
   logic [XW-1:0] down_x_ff, down_x_in;
   logic [XW-1:0] down_y_ff, down_y_in;
   logic [XW-1:0] last_x_ff, last_x_in;
   logic [XW-1:0] last_y_ff, last_y_in;
   logic [tpgt_pkg::TOTAL_W-1:0] counter_ff, counter_in;

   logic [XW-1:0] px;
   logic [XW-1:0] py;
   logic [XW-1:0] thr;
   logic [XW-1:0] dx;
   logic [XW-1:0] dy;
   logic [1:0]    need;
   logic          swipe;

   tpgt_xform u_xform (
      .cfg     (cfg),
      .raw_x   (raw_x),
      .raw_y   (raw_y),
      .point_x (px),
      .point_y (py)
   );

   always_comb begin
      thr = (cfg.swipe_distance != '0) ? cfg.swipe_distance : tpgt_pkg::DEF_SWIPE;
      dx = (last_x_ff > down_x_ff) ? (last_x_ff - down_x_ff) : (down_x_ff - last_x_ff);
      dy = (last_y_ff > down_y_ff) ? (last_y_ff - down_y_ff) : (down_y_ff - last_y_ff);
      swipe = (dx > thr) || (dy > thr);

      if (!cfg.enable || read_failed) begin
         need = 2'd0;
      end else if (touched) begin
         need = 2'd1;
      end else if (pressed_ff) begin
         need = 2'd2;
      end else begin
         need = 2'd0;
      end
      take = in_valid && (need <= free);
      push_cnt = take ? need : 2'd0;

      ev0 = '0;
      ev1 = '0;
      if (touched) begin
         ev0.event_kind = pressed_ff ? tpgt_pkg::EV_MOVE : tpgt_pkg::EV_DOWN;
         ev0.point_x = px;
         ev0.point_y = py;
         ev0.is_pressed = 1'b1;
         ev0.event_total = counter_ff + tpgt_pkg::TOTAL_W'(1);
         ev0.last_of_run = 1'b1;
      end else begin
         ev0.event_kind = tpgt_pkg::EV_UP;
         ev0.point_x = last_x_ff;
         ev0.point_y = last_y_ff;
         ev0.is_pressed = 1'b0;
         ev0.event_total = counter_ff + tpgt_pkg::TOTAL_W'(1);
         ev0.last_of_run = 1'b0;
      end
      ev1.event_kind = swipe ? tpgt_pkg::EV_SWIPE : tpgt_pkg::EV_CLICK;
      ev1.point_x = last_x_ff;
      ev1.point_y = last_y_ff;
      ev1.is_pressed = 1'b0;
      ev1.event_total = counter_ff + tpgt_pkg::TOTAL_W'(2);
      ev1.last_of_run = 1'b1;

      pressed_in = pressed_ff;
      down_x_in = down_x_ff;
      down_y_in = down_y_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      counter_in = counter_ff + tpgt_pkg::TOTAL_W'(push_cnt);
      if (take && need == 2'd1) begin
         pressed_in = 1'b1;
         last_x_in = px;
         last_y_in = py;
         if (!pressed_ff) begin
            down_x_in = px;
            down_y_in = py;
         end
      end else if (take && need == 2'd2) begin
         pressed_in = 1'b0;
      end
      if (clear_press) begin
         pressed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         down_x_ff <= '0;
         down_y_ff <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         counter_ff <= '0;
      end else begin
         pressed_ff <= pressed_in;
         down_x_ff <= down_x_in;
         down_y_ff <= down_y_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         counter_ff <= counter_in;
      end
   end

   a_idle_unpressed: assert property (@(posedge clock) disable iff (reset)
      !cfg.enable |-> !pressed_ff)
      else $error("pressed state held while disabled");

   a_release_pair: assert property (@(posedge clock) disable iff (reset)
      push_cnt == 2'd2 |-> pressed_ff && ev0.event_kind == tpgt_pkg::EV_UP
         && (ev1.event_kind == tpgt_pkg::EV_CLICK || ev1.event_kind == tpgt_pkg::EV_SWIPE))
      else $error("two results pushed outside a release");

   a_release_drops: assert property (@(posedge clock) disable iff (reset)
      push_cnt == 2'd2 |=> !pressed_ff)
      else $error("pressed state kept after release");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |=> counter_ff == $past(counter_ff) + tpgt_pkg::TOTAL_W'($past(push_cnt)))
      else $error("event counter out of step");

endmodule

FILE: sv/tpgt_rsp_queue.sv
module tpgt_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_cnt,
   input  tpgt_pkg::evt_type    ev0,
   input  tpgt_pkg::evt_type    ev1,
   input  logic                 pop,
   output logic                 out_valid,
   output tpgt_pkg::evt_type    head,
   output logic [1:0]           free
);

   tpgt_pkg::evt_type e0_ff, e0_in;
   tpgt_pkg::evt_type e1_ff, e1_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] kept;
   logic       do_pop;

   always_comb begin
      do_pop = pop && (count_ff != 2'd0);
      e0_in = e0_ff;
      e1_in = e1_ff;
      kept = count_ff;
      if (do_pop) begin
         e0_in = e1_ff;
         kept = count_ff - 2'd1;
      end
      if (push_cnt != 2'd0) begin
         if (kept == 2'd0) begin
            e0_in = ev0;
         end else begin
            e1_in = ev0;
         end
      end
      if (push_cnt == 2'd2) begin
         e1_in = ev1;
      end
      count_in = kept + push_cnt;
      out_valid = (count_ff != 2'd0);
      head = e0_ff;
      free = 2'd2 - count_ff + {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_cnt <= free)
      else $error("response queue overflow");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("response queue depth exceeded");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push_cnt == 2'd2 && count_ff == 2'd0 |=> count_ff == 2'd2 && !head.last_of_run)
      else $error("release pair stored out of order");

endmodule

FILE: sv/touch_point_gesture_tracker_top.sv
// Touch-panel gesture tracker. Each request is one panel poll (touched flag,
// raw point, read-failure flag); the point is rotated, optionally mirrored and
// clamped to the configured screen, and turned into DOWN, MOVE, UP and then
// CLICK or SWIPE events. A poll is taken into an input register, evaluated in
// a single combinational pass against the gesture state, and its events go
// into a two-entry response queue. A poll is taken once the queue has room for
// its events, and a new one is accepted as it is taken. A release yields two
// events; the response port drains one event per cycle while rsp_tready is high.
// Failed reads, polls while disabled and releases without a press produce
// nothing. Writing enable to zero drops the pressed state. Configuration must be
// written only while no request is in flight; the block does not enforce this.
module touch_point_gesture_tracker_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_x[15:0], raw_y[31:16]
   input  logic [31:0]                       req_tdata,
   // touched[0], read_failed[1]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // point_x[11:0], point_y[23:12], is_pressed[24], event_total[56:25], zero[63:57]
   output logic [63:0]                       rsp_tdata,
   // event_kind[2:0]
   output logic [2:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tpgt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int XW = tpgt_pkg::COORD_W;

   tpgt_pkg::cfg_type cfg_ff, cfg_in;
   logic       clear_press;
   logic       csr_wr;
   logic [2:0] csr_idx;

   logic       in_valid_ff, in_valid_in;
   logic       touched_ff;
   logic       failed_ff;
   logic [tpgt_pkg::RAW_W-1:0] raw_x_ff;
   logic [tpgt_pkg::RAW_W-1:0] raw_y_ff;

   logic       take;
   logic [1:0] push_cnt;
   logic [1:0] free;
   tpgt_pkg::evt_type ev0;
   tpgt_pkg::evt_type ev1;
   tpgt_pkg::evt_type head;

   always_comb begin
      csr_pready = 1'b1;
      csr_idx = csr_paddr[4:2];
      csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in = cfg_ff;
      clear_press = 1'b0;
      if (csr_wr) begin
         case (csr_idx)
            tpgt_pkg::REG_ENABLE: begin
               cfg_in.enable = csr_pwdata[0];
               clear_press = !csr_pwdata[0];
            end
            tpgt_pkg::REG_WIDTH: cfg_in.screen_width = csr_pwdata[XW-1:0];
            tpgt_pkg::REG_HEIGHT: cfg_in.screen_height = csr_pwdata[XW-1:0];
            tpgt_pkg::REG_ROTATION: cfg_in.rotation = csr_pwdata[1:0];
            tpgt_pkg::REG_FLIP_H: cfg_in.flip_horizontal = csr_pwdata[0];
            tpgt_pkg::REG_FLIP_V: cfg_in.flip_vertical = csr_pwdata[0];
            tpgt_pkg::REG_SWIPE: cfg_in.swipe_distance = csr_pwdata[XW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
      case (csr_idx)
         tpgt_pkg::REG_ENABLE: csr_prdata = {31'd0, cfg_ff.enable};
         tpgt_pkg::REG_WIDTH: csr_prdata = {20'd0, cfg_ff.screen_width};
         tpgt_pkg::REG_HEIGHT: csr_prdata = {20'd0, cfg_ff.screen_height};
         tpgt_pkg::REG_ROTATION: csr_prdata = {30'd0, cfg_ff.rotation};
         tpgt_pkg::REG_FLIP_H: csr_prdata = {31'd0, cfg_ff.flip_horizontal};
         tpgt_pkg::REG_FLIP_V: csr_prdata = {31'd0, cfg_ff.flip_vertical};
         tpgt_pkg::REG_SWIPE: csr_prdata = {20'd0, cfg_ff.swipe_distance};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.screen_width <= tpgt_pkg::DEF_WIDTH;
         cfg_ff.screen_height <= tpgt_pkg::DEF_HEIGHT;
         cfg_ff.rotation <= tpgt_pkg::ROT_NONE;
         cfg_ff.flip_horizontal <= 1'b0;
         cfg_ff.flip_vertical <= 1'b0;
         cfg_ff.swipe_distance <= tpgt_pkg::DEF_SWIPE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_tready = !in_valid_ff || take;
      in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (in_valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         raw_x_ff <= req_tdata[15:0];
         raw_y_ff <= req_tdata[31:16];
         touched_ff <= req_tuser[0];
         failed_ff <= req_tuser[1];
      end
   end

   tpgt_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .clear_press (clear_press),
      .in_valid    (in_valid_ff),
      .touched     (touched_ff),
      .raw_x       (raw_x_ff),
      .raw_y       (raw_y_ff),
      .read_failed (failed_ff),
      .free        (free),
      .take        (take),
      .push_cnt    (push_cnt),
      .ev0         (ev0),
      .ev1         (ev1)
   );

   tpgt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .ev0       (ev0),
      .ev1       (ev1),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .head      (head),
      .free      (free)
   );

   assign rsp_tdata = {7'd0, head.event_total, head.is_pressed, head.point_y, head.point_x};
   assign rsp_tuser = head.event_kind;
   assign rsp_tlast = head.last_of_run;

endmodule
